[rtl/swarq_pkg.sv]
`default_nettype none
package swarq_pkg;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned SEQ_W = 8;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned TICK_W = 16;
    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd500;

    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_RECV = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_ACK = 2'd1;

    localparam logic [1:0] OUT_DATA = 2'd0;
    localparam logic [1:0] OUT_ACK = 2'd1;
    localparam logic [1:0] OUT_DELIVER = 2'd2;
    localparam logic [1:0] OUT_REFUSE = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE = 4'b0001,
        CMD_SEND = 4'b0010,
        CMD_ACK  = 4'b0100,
        CMD_DATA = 4'b1000
    } cmd_kind_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [SEQ_W-1:0]  ack_num;
        logic [DATA_W-1:0] payload;
        logic              tick;
        cmd_kind_t         kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [SEQ_W-1:0]  out_ack;
        logic [DATA_W-1:0] out_payload;
        logic              out_last;
    } result_t;

endpackage
`default_nettype wire

[rtl/swarq_front.sv]
`default_nettype none
module swarq_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      func,
    input  wire logic [1:0]                      frame_kind,
    input  wire logic [swarq_pkg::SEQ_W-1:0]     seq_num,
    input  wire logic [swarq_pkg::SEQ_W-1:0]     ack_num,
    input  wire logic [swarq_pkg::DATA_W-1:0]    payload,
    output logic                                 cmd_valid,
    input  wire logic                            cmd_ready,
    output swarq_pkg::cmd_t                      cmd
);
    import swarq_pkg::*;

    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg;
    logic rp_reg;
    cmd_t c;
    logic push;
    logic pop;

    always_comb
    begin
        c.seq_num = seq_num;
        c.ack_num = ack_num;
        c.payload = payload;
        c.tick = 1'b0;
        c.kind = CMD_NONE;
        case (func)
            FUNC_SEND: c.kind = CMD_SEND;
            FUNC_RECV:
            begin
                if (frame_kind == FRAME_ACK)
                    c.kind = CMD_ACK;
                else if (frame_kind == FRAME_DATA)
                    c.kind = CMD_DATA;
            end
            FUNC_TICK: c.tick = 1'b1;
            default: c.kind = CMD_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && (c.kind != CMD_NONE || c.tick);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

[rtl/swarq_back.sv]
`default_nettype none
module swarq_back
#(
    parameter int unsigned SEND_WINDOW = 4,
    parameter int unsigned RECV_WINDOW = 4
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [swarq_pkg::TICK_W-1:0]    cfg_data,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire swarq_pkg::cmd_t                 cmd,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output swarq_pkg::result_t                   res
);
    import swarq_pkg::*;

    localparam int unsigned SW_W = (SEND_WINDOW > 1) ? $clog2(SEND_WINDOW) : 1;
    localparam int unsigned RW_W = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
    localparam int unsigned SC_W = $clog2(SEND_WINDOW + 1);
    localparam int unsigned RC_W = $clog2(RECV_WINDOW + 1);
    localparam logic [SEQ_W-1:0] SEND_WIN = SEQ_W'(SEND_WINDOW);
    localparam logic [SEQ_W-1:0] RECV_WIN = SEQ_W'(RECV_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TICK = 4'b0010,
        ST_DLV  = 4'b0100,
        ST_ACKO = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [TICK_W-1:0] ticks_reg;
    logic [SEQ_W-1:0] oldest_reg, nts_reg, nexp_reg;
    logic [DATA_W-1:0] sbuf_reg [SEND_WINDOW];
    logic [TICK_W-1:0] stim_reg [SEND_WINDOW];
    logic [DATA_W-1:0] rbuf_reg [RECV_WINDOW];
    logic [RECV_WINDOW-1:0] rvalid_reg;
    logic [SC_W-1:0] idx_reg;
    logic [SC_W-1:0] lim_reg;
    logic [RC_W-1:0] guard_reg;
    logic rv_reg;
    result_t r_reg;

    logic [SEQ_W-1:0] outst, s8, rpos, apos;
    logic [SW_W-1:0] sslot, tslot;
    logic [RW_W-1:0] rslot, eslot;
    logic free_out;
    logic emit;
    result_t er;
    logic [SC_W-1:0] lim_c;

    assign outst = nts_reg - oldest_reg;
    assign lim_c = (outst > SEND_WIN) ? SC_W'(SEND_WINDOW) : SC_W'(outst);
    assign s8 = oldest_reg + SEQ_W'(idx_reg);
    assign sslot = SW_W'(nts_reg % SEND_WIN);
    assign tslot = SW_W'(s8 % SEND_WIN);
    assign rslot = RW_W'(cmd.seq_num % RECV_WIN);
    assign eslot = RW_W'(nexp_reg % RECV_WIN);
    assign rpos = cmd.seq_num - nexp_reg;
    assign apos = cmd.ack_num - oldest_reg;
    assign free_out = !rv_reg || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && free_out;
    assign res_valid = rv_reg;
    assign res = r_reg;

    always_comb
    begin
        state_next = state_reg;
        emit = 1'b0;
        er = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && free_out)
                begin
                    if (cmd.tick)
                        state_next = (lim_c == '0) ? ST_IDLE : ST_TICK;
                    else
                    begin
                        case (cmd.kind)
                            CMD_SEND:
                            begin
                                emit = 1'b1;
                                er.out_last = 1'b1;
                                if (outst >= SEND_WIN)
                                    er.out_kind = OUT_REFUSE;
                                else
                                begin
                                    er.out_kind = OUT_DATA;
                                    er.out_seq = nts_reg;
                                    er.out_payload = cmd.payload;
                                end
                            end
                            CMD_DATA:
                            begin
                                if (rpos < RECV_WIN && cmd.seq_num == nexp_reg)
                                    state_next = ST_DLV;
                            end
                            default: state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_TICK:
            begin
                if (free_out)
                begin
                    if (stim_reg[tslot] <= 16'd1)
                    begin
                        emit = 1'b1;
                        er.out_kind = OUT_DATA;
                        er.out_seq = s8;
                        er.out_payload = sbuf_reg[tslot];
                        er.out_last = 1'b1;
                        for (int j = 0; j < SEND_WINDOW; j++)
                        begin
                            if (SC_W'(j) > idx_reg && SC_W'(j) < lim_reg)
                            begin
                                if (stim_reg[SW_W'((oldest_reg + SEQ_W'(j)) % SEND_WIN)]
                                    <= 16'd1)
                                    er.out_last = 1'b0;
                            end
                        end
                    end
                    if (idx_reg + 1'b1 >= lim_reg)
                        state_next = ST_IDLE;
                end
            end
            ST_DLV:
            begin
                if (free_out)
                begin
                    if (rvalid_reg[eslot] && guard_reg < RC_W'(RECV_WINDOW))
                    begin
                        emit = 1'b1;
                        er.out_kind = OUT_DELIVER;
                        er.out_seq = nexp_reg;
                        er.out_payload = rbuf_reg[eslot];
                    end
                    else
                        state_next = ST_ACKO;
                end
            end
            ST_ACKO:
            begin
                if (free_out)
                begin
                    emit = 1'b1;
                    er.out_kind = OUT_ACK;
                    er.out_ack = nexp_reg - 1'b1;
                    er.out_last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            r_reg <= er;
        if (state_reg == ST_IDLE && cmd_valid && free_out && !cmd.tick)
        begin
            if (cmd.kind == CMD_SEND && outst < SEND_WIN)
                sbuf_reg[sslot] <= cmd.payload;
            if (cmd.kind == CMD_DATA && rpos < RECV_WIN)
                rbuf_reg[rslot] <= cmd.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ticks_reg <= TICKS_RESET;
            oldest_reg <= '0;
            nts_reg <= '0;
            nexp_reg <= '0;
            rvalid_reg <= '0;
            idx_reg <= '0;
            lim_reg <= '0;
            guard_reg <= '0;
            rv_reg <= 1'b0;
            for (int i = 0; i < SEND_WINDOW; i++)
                stim_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                ticks_reg <= cfg_data;
            if (emit)
                rv_reg <= 1'b1;
            else if (res_ready)
                rv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    lim_reg <= lim_c;
                    guard_reg <= '0;
                    if (cmd_valid && free_out && !cmd.tick)
                    begin
                        case (cmd.kind)
                            CMD_SEND:
                            begin
                                if (outst < SEND_WIN)
                                begin
                                    stim_reg[sslot] <= ticks_reg;
                                    nts_reg <= nts_reg + 1'b1;
                                end
                            end
                            CMD_ACK:
                            begin
                                if (apos < outst)
                                    oldest_reg <= cmd.ack_num + 1'b1;
                            end
                            CMD_DATA:
                            begin
                                if (rpos < RECV_WIN)
                                    rvalid_reg[rslot] <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (free_out)
                    begin
                        if (stim_reg[tslot] <= 16'd1)
                            stim_reg[tslot] <= ticks_reg;
                        else
                            stim_reg[tslot] <= stim_reg[tslot] - 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DLV:
                begin
                    if (free_out && rvalid_reg[eslot] && guard_reg < RC_W'(RECV_WINDOW))
                    begin
                        rvalid_reg[eslot] <= 1'b0;
                        nexp_reg <= nexp_reg + 1'b1;
                        guard_reg <= guard_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/sliding_window_arq_engine_top.sv]
`default_nettype none
// Channel  Dir  tdata                                        tuser       tlast
// s_axis   in   seq_num, ack_num, payload (80 bits)          func,kind   -
// m_axis   out  out_seq, out_ack, out_payload (80 bits)      out_kind    out_last
// cfg      in   retransmit_ticks (16 bits, cfg_we strobe)    -           -
// A send, an ack or a data frame that delivers nothing is handled in the idle state; a data
// frame that delivers passes through a delivery state, one payload per step, and then an
// ack-out state; a tick with outstanding slots walks each of them in the tick state.
// The back-end sequencer walks the window one slot a cycle while the output is not stalled.
// Reset clears all control state and loads retransmit_ticks with 500.
// A two-entry queue parts the front from the back; a full output register stalls the back.
module sliding_window_arq_engine_top
#(
    parameter int unsigned SEND_WINDOW = 4,
    parameter int unsigned RECV_WINDOW = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // seq_num, ack_num, payload
    input  wire logic [3:0]  s_axis_tuser,  // func, frame_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // out_seq, out_ack, out_payload
    output logic [1:0]       m_axis_tuser,  // out_kind
    output logic             m_axis_tlast
);
    import swarq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    result_t res;

    swarq_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .func       (s_axis_tuser[1:0]),
        .frame_kind (s_axis_tuser[3:2]),
        .seq_num    (s_axis_tdata[7:0]),
        .ack_num    (s_axis_tdata[15:8]),
        .payload    (s_axis_tdata[79:16]),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    swarq_back #(.SEND_WINDOW(SEND_WINDOW), .RECV_WINDOW(RECV_WINDOW)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.out_payload, res.out_ack, res.out_seq};
    assign m_axis_tuser = res.out_kind;
    assign m_axis_tlast = res.out_last;

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import swarq_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [1:0]  kind;
        logic [7:0]  seq;
        logic [7:0]  ack;
        logic [63:0] data;
        logic        is_cfg;
        logic [15:0] cfg;
    } arq_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  seq;
        logic [7:0]  ack;
        logic [63:0] data;
        logic        last;
    } arq_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sliding_window_arq_engine_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    arq_item_t   pending_items[$];
    arq_result_t expected_results[$];
    int          error_count = 0;
    bit          stim_done = 0;
    bit          hold_off = 1'b0;

    logic [7:0]  mdl_oldest;
    logic [7:0]  mdl_next_send;
    logic [7:0]  mdl_next_exp;
    logic [63:0] mdl_send_buf[4];
    logic [15:0] mdl_send_timer[4];
    logic [63:0] mdl_recv_buf[4];
    logic        mdl_recv_valid[4];
    logic [15:0] mdl_ticks;

    function automatic arq_result_t mk(logic [1:0] k, logic [7:0] s, logic [7:0] a,
                                       logic [63:0] d);
        arq_result_t r;
        r.kind = k;
        r.seq = s;
        r.ack = a;
        r.data = d;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_arq(arq_item_t it);
        arq_result_t res[$];
        logic [7:0]  outstanding;
        logic [7:0]  pos;
        logic [7:0]  s8;
        int          guard;
        outstanding = mdl_next_send - mdl_oldest;
        if (it.func == FUNC_SEND)
        begin
            if (outstanding >= 4)
            begin
                res.push_back(mk(OUT_REFUSE, 8'd0, 8'd0, 64'd0));
            end
            else
            begin
                mdl_send_buf[mdl_next_send[1:0]] = it.data;
                mdl_send_timer[mdl_next_send[1:0]] = mdl_ticks;
                res.push_back(mk(OUT_DATA, mdl_next_send, 8'd0, it.data));
                mdl_next_send = mdl_next_send + 8'd1;
            end
        end
        else if (it.func == FUNC_RECV && it.kind == FRAME_ACK)
        begin
            pos = it.ack - mdl_oldest;
            if (pos < outstanding)
                mdl_oldest = it.ack + 8'd1;
        end
        else if (it.func == FUNC_RECV && it.kind == FRAME_DATA)
        begin
            pos = it.seq - mdl_next_exp;
            if (pos < 4)
            begin
                mdl_recv_buf[it.seq[1:0]] = it.data;
                mdl_recv_valid[it.seq[1:0]] = 1'b1;
                if (it.seq == mdl_next_exp)
                begin
                    guard = 0;
                    while (mdl_recv_valid[mdl_next_exp[1:0]] && guard < 4)
                    begin
                        res.push_back(mk(OUT_DELIVER, mdl_next_exp, 8'd0,
                                         mdl_recv_buf[mdl_next_exp[1:0]]));
                        mdl_recv_valid[mdl_next_exp[1:0]] = 1'b0;
                        mdl_next_exp = mdl_next_exp + 8'd1;
                        guard++;
                    end
                    res.push_back(mk(OUT_ACK, 8'd0, mdl_next_exp - 8'd1, 64'd0));
                end
            end
        end
        else if (it.func == FUNC_TICK)
        begin
            for (int i = 0; i < outstanding && i < 4; i++)
            begin
                s8 = mdl_oldest + 8'(i);
                if (mdl_send_timer[s8[1:0]] <= 16'd1)
                begin
                    mdl_send_timer[s8[1:0]] = mdl_ticks;
                    res.push_back(mk(OUT_DATA, s8, 8'd0, mdl_send_buf[s8[1:0]]));
                end
                else
                begin
                    mdl_send_timer[s8[1:0]] = mdl_send_timer[s8[1:0]] - 16'd1;
                end
            end
        end
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
        foreach (res[i])
            expected_results.push_back(res[i]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    int in_gap = 0;
    bit cfg_wait = 0;
    int settle = 0;

    always @(posedge clk or negedge rst_n)
    begin : p_drive
        bit cfg_fire;
        cfg_fire = 1'b0;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            cfg_data <= '0;
            in_gap <= 0;
            settle <= 0;
        end
        else
        begin
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    predict_arq(pending_items.pop_front());
                end
                if (in_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (pending_items.size() > 0 && pending_items[0].is_cfg)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (expected_results.size() != 0 || s_axis_tvalid)
                        settle <= 0;
                    else if (settle < 20)
                        settle <= settle + 1;
                    else
                    begin
                        cfg_fire = 1'b1;
                        cfg_data <= pending_items[0].cfg;
                        mdl_ticks = pending_items[0].cfg;
                        void'(pending_items.pop_front());
                        settle <= 0;
                    end
                end
                else if (pending_items.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_items[0].data, pending_items[0].ack,
                                     pending_items[0].seq};
                    s_axis_tuser <= {pending_items[0].kind, pending_items[0].func};
                    in_gap <= pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
        cfg_we <= cfg_fire;
    end

    initial
    begin
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    int out_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result kind=%0d", m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    arq_result_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tuser !== e.kind)
                    begin
                        $error("out_kind exp %0d got %0d", e.kind, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[7:0] !== e.seq)
                    begin
                        $error("out_seq exp %0d got %0d", e.seq, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[15:8] !== e.ack)
                    begin
                        $error("out_ack exp %0d got %0d", e.ack, m_axis_tdata[15:8]);
                        error_count++;
                    end
                    if (m_axis_tdata[79:16] !== e.data)
                    begin
                        $error("out_payload exp %h got %h", e.data, m_axis_tdata[79:16]);
                        error_count++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $error("out_last exp %0d got %0d", e.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    function automatic arq_item_t mk_item(logic [1:0] f, logic [1:0] k, logic [7:0] s,
                                          logic [7:0] a, logic [63:0] d);
        arq_item_t it;
        it.func = f;
        it.kind = k;
        it.seq = s;
        it.ack = a;
        it.data = d;
        it.is_cfg = 1'b0;
        it.cfg = '0;
        return it;
    endfunction

    function automatic arq_item_t mk_cfg(logic [15:0] v);
        arq_item_t it;
        it = mk_item(FUNC_SEND, FRAME_DATA, 8'd0, 8'd0, 64'd0);
        it.is_cfg = 1'b1;
        it.cfg = v;
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_random(int n);
        logic [7:0] rseq;
        logic [7:0] nexp;
        int         r;
        nexp = 8'd0;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                pending_items.push_back(mk_item(FUNC_SEND, 2'($urandom()), 8'($urandom()),
                                                8'($urandom()), rnd64()));
            end
            else if (r < 45)
            begin
                pending_items.push_back(mk_item(FUNC_RECV, FRAME_ACK, 8'($urandom()),
                                                8'($urandom()), rnd64()));
            end
            else if (r < 75)
            begin
                rseq = (r < 70) ? nexp + 8'($urandom_range(0, 3)) : 8'($urandom());
                if (rseq == nexp)
                    nexp = nexp + 8'd1;
                pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, rseq,
                                                8'($urandom()), rnd64()));
            end
            else if (r < 95)
            begin
                pending_items.push_back(mk_item(FUNC_TICK, 2'($urandom()), 8'($urandom()),
                                                8'($urandom()), rnd64()));
            end
            else if (r < 97)
            begin
                pending_items.push_back(mk_item(FUNC_RECV, 2'($urandom_range(2, 3)),
                                                8'($urandom()), 8'($urandom()), rnd64()));
            end
            else
            begin
                pending_items.push_back(mk_item(2'd3, 2'($urandom()), 8'($urandom()),
                                                8'($urandom()), rnd64()));
            end
        end
    endtask

    initial
    begin
        mdl_oldest = 0;
        mdl_next_send = 0;
        mdl_next_exp = 0;
        mdl_ticks = TICKS_RESET;
        for (int i = 0; i < 4; i++)
        begin
            mdl_send_buf[i] = '0;
            mdl_send_timer[i] = '0;
            mdl_recv_buf[i] = '0;
            mdl_recv_valid[i] = 1'b0;
        end
        rst_n = 1'b0;

        pending_items.push_back(mk_cfg(16'd2));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(mk_item(FUNC_SEND, FRAME_DATA, 8'd0, 8'd0,
                                            (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rnd64()));
        pending_items.push_back(mk_item(FUNC_TICK, FRAME_DATA, 8'd0, 8'd0, 64'd0));
        pending_items.push_back(mk_item(FUNC_TICK, FRAME_DATA, 8'd0, 8'd0, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_ACK, 8'd0, 8'd200, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_ACK, 8'd0, 8'd1, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_ACK, 8'd0, 8'd3, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_ACK, 8'hFF, 8'd3, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd2, 8'hFF, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd1, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd3, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd1, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd9, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_RECV, FRAME_DATA, 8'd0, 8'd0, 64'd0));
        pending_items.push_back(mk_item(FUNC_RECV, 2'd2, 8'd4, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_RECV, 2'd3, 8'd4, 8'd0, rnd64()));
        pending_items.push_back(mk_item(2'd3, 2'd3, 8'hFF, 8'hFF, rnd64()));
        pending_items.push_back(mk_cfg(16'd0));
        pending_items.push_back(mk_item(FUNC_SEND, FRAME_DATA, 8'd0, 8'd0, rnd64()));
        pending_items.push_back(mk_item(FUNC_TICK, FRAME_DATA, 8'd0, 8'd0, 64'd0));
        pending_items.push_back(mk_cfg(16'hFFFF));
        pending_items.push_back(mk_item(FUNC_TICK, FRAME_DATA, 8'd0, 8'd0, 64'd0));
        pending_items.push_back(mk_cfg(16'd1));
        add_random(80);
        pending_items.push_back(mk_cfg(16'd3));
        add_random(90);
        pending_items.push_back(mk_cfg(16'd500));
        add_random(80);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
